// ----- rtl/core/rse_pkg.sv -----
// Shared types and codes of the reservation station entry.
package rse_pkg;

    // Operation codes carried in the input tuser
    localparam logic [1:0] OP_ISSUE = 2'd0;
    localparam logic [1:0] OP_BCAST = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    // Instruction opcodes
    localparam logic [2:0] OPC_ADD   = 3'd0;
    localparam logic [2:0] OPC_SUB   = 3'd1;
    localparam logic [2:0] OPC_MUL   = 3'd2;
    localparam logic [2:0] OPC_DIV   = 3'd3;
    localparam logic [2:0] OPC_SLT   = 3'd4;
    localparam logic [2:0] OPC_SGT   = 3'd5;
    localparam logic [2:0] OPC_LOAD  = 3'd6;
    localparam logic [2:0] OPC_STORE = 3'd7;

    // Result kinds carried in the output tuser
    localparam logic [1:0] KIND_ALU   = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_STORE = 2'd2;

    localparam int ADDR_WIDTH = 32;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ABS_K,
        ST_LOOP,
        ST_FIX,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/core/reservation_station_entry.sv -----
// Tomasulo reservation station entry with an iterative shared adder datapath.
//
//  Channel   Dir  Handshake                      Payload
//  --------  ---  -----------------------------  ---------------------------------------
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: operation; tdata: issue/bcast
//  m_axis    out  m_axis_tvalid / m_axis_tready  tuser: kind; tdata: result fields
//  cfg       in   i_cfg_wr_en                    i_cfg_wr_data: memory_station
//
//  Steps: an item that leaves an operand missing only updates the entry. Once both operands
//  are present the sequencer runs the instruction: the shared add/subtract unit does add,
//  sub and compare, while a separate adder forms the memory address. Multiply runs one
//  shift-add per multiplier bit and a fix step; divide runs two magnitude steps, one
//  restoring step per quotient bit and a sign fix. s_axis_tready is low meanwhile.
//  Reset: synchronous, active low; clears the sequencer, busy flag, output valid and
//  the memory_station register. A result waiting in the output register does not
//  block new transfers; only a new result that finds it still occupied waits.
module reservation_station_entry #(
    parameter int TAG_WIDTH  = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,

    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,

    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // from bit 0: opcode, value_j, value_k, tag_j, tag_k, base_address, dest_tag,
    // bcast_tag, bcast_value, zero fill
    input  logic [((3 + 3 * DATA_WIDTH + 4 * TAG_WIDTH + rse_pkg::ADDR_WIDTH + 7) / 8) * 8 - 1:0]
                 s_axis_tdata,
    // from bit 0: operation
    input  logic [1:0] s_axis_tuser,

    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // from bit 0: result_tag, result_value, mem_address, divide_by_zero, zero fill
    output logic [((TAG_WIDTH + DATA_WIDTH + rse_pkg::ADDR_WIDTH + 1 + 7) / 8) * 8 - 1:0]
                 m_axis_tdata,
    // from bit 0: kind
    output logic [1:0] m_axis_tuser
);
    import rse_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int TW    = TAG_WIDTH;
    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam int OUT_W = ((TW + DW + ADDR_WIDTH + 1 + 7) / 8) * 8;

    // Input field offsets in tdata
    localparam int OPC_LO = 0;
    localparam int VJ_LO  = 3;
    localparam int VK_LO  = VJ_LO + DW;
    localparam int TJ_LO  = VK_LO + DW;
    localparam int TK_LO  = TJ_LO + TW;
    localparam int BA_LO  = TK_LO + TW;
    localparam int DT_LO  = BA_LO + ADDR_WIDTH;
    localparam int BT_LO  = DT_LO + TW;
    localparam int BV_LO  = BT_LO + TW;

    localparam logic [DW-1:0] SIGN_MASK = {1'b1, {(DW-1){1'b0}}};

    // Unpacked input fields
    logic [1:0]            in_op;
    logic [2:0]            in_opc;
    logic [DW-1:0]         in_vj, in_vk, in_bv;
    logic [TW-1:0]         in_tj, in_tk, in_dt, in_bt;
    logic [ADDR_WIDTH-1:0] in_ba;

    assign in_op  = s_axis_tuser;
    assign in_opc = s_axis_tdata[OPC_LO +: 3];
    assign in_vj  = s_axis_tdata[VJ_LO +: DW];
    assign in_vk  = s_axis_tdata[VK_LO +: DW];
    assign in_tj  = s_axis_tdata[TJ_LO +: TW];
    assign in_tk  = s_axis_tdata[TK_LO +: TW];
    assign in_ba  = s_axis_tdata[BA_LO +: ADDR_WIDTH];
    assign in_dt  = s_axis_tdata[DT_LO +: TW];
    assign in_bt  = s_axis_tdata[BT_LO +: TW];
    assign in_bv  = s_axis_tdata[BV_LO +: DW];

    // Control state
    t_state r_state, n_state;
    logic   r_busy;
    logic   r_mem_station;
    logic   r_out_valid;

    // Entry contents; operands double as working registers once the entry fires
    logic [2:0]            r_opcode;
    logic [DW-1:0]         r_opj, r_opk;
    logic [TW-1:0]         r_wait_j, r_wait_k;
    logic [ADDR_WIDTH-1:0] r_addr;
    logic [TW-1:0]         r_dest;

    // Sequencer working state
    logic [DW:0]           r_acc;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_neg;

    // Finished result waiting for the output register
    logic [1:0]            r_pend_kind;
    logic [DW-1:0]         r_pend_value;
    logic [ADDR_WIDTH-1:0] r_pend_addr;
    logic                  r_pend_dz;

    // Output register
    logic [1:0]            r_out_kind;
    logic [TW-1:0]         r_out_tag;
    logic [DW-1:0]         r_out_value;
    logic [ADDR_WIDTH-1:0] r_out_addr;
    logic                  r_out_dz;

    // Shared adder
    logic [DW:0] add_x, add_y, add_sum;
    logic        add_sub;

    logic s_xfer, out_free, in_fire, last_step, is_div;
    logic [ADDR_WIDTH-1:0] eff_addr;
    logic qbit;

    assign s_xfer    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign last_step = (r_cnt == CNT_W'(DW - 1));
    assign is_div    = (r_opcode == OPC_DIV);
    assign add_sum   = add_x + (add_sub ? ~add_y : add_y) + (DW+1)'(add_sub);
    assign eff_addr  = r_addr + ADDR_WIDTH'(r_opk);
    assign qbit      = !add_sum[DW];

    // Operands complete with this transfer
    always_comb begin
        in_fire = 1'b0;
        priority if (in_op == OP_ISSUE) begin
            in_fire = !r_busy && (in_tj == '0) && (in_tk == '0);
        end else if (in_op == OP_BCAST) begin
            in_fire = r_busy && (in_bt != '0) && ((r_wait_j != '0) || (r_wait_k != '0))
                   && ((r_wait_j == '0) || (r_wait_j == in_bt))
                   && ((r_wait_k == '0) || (r_wait_k == in_bt));
        end else begin
            in_fire = 1'b0;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_xfer && in_fire) n_state = ST_START;
            ST_START: begin
                if (!r_mem_station && r_opcode == OPC_MUL) begin
                    n_state = ST_LOOP;
                end else if (!r_mem_station && is_div && r_opk != '0) begin
                    n_state = ST_ABS_K;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_ABS_K: n_state = ST_LOOP;
            ST_LOOP:  if (last_step) n_state = ST_FIX;
            ST_FIX:   n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and adder operand selection
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            ST_START: begin
                unique case (r_opcode)
                    OPC_ADD: begin
                        add_x = {1'b0, r_opj};
                        add_y = {1'b0, r_opk};
                    end
                    OPC_SUB: begin
                        add_x   = {1'b0, r_opj};
                        add_y   = {1'b0, r_opk};
                        add_sub = 1'b1;
                    end
                    OPC_SLT: begin
                        add_x   = {1'b0, r_opj ^ SIGN_MASK};
                        add_y   = {1'b0, r_opk ^ SIGN_MASK};
                        add_sub = 1'b1;
                    end
                    OPC_SGT: begin
                        add_x   = {1'b0, r_opk ^ SIGN_MASK};
                        add_y   = {1'b0, r_opj ^ SIGN_MASK};
                        add_sub = 1'b1;
                    end
                    OPC_DIV: begin
                        add_y   = {1'b0, r_opj};
                        add_sub = 1'b1;
                    end
                    default: add_sub = 1'b0;
                endcase
            end
            ST_ABS_K: begin
                add_y   = {1'b0, r_opk};
                add_sub = 1'b1;
            end
            ST_LOOP: begin
                if (is_div) begin
                    add_x   = {r_acc[DW-1:0], r_opj[DW-1]};
                    add_y   = {1'b0, r_opk};
                    add_sub = 1'b1;
                end else begin
                    add_x = r_acc;
                    add_y = {1'b0, r_opj};
                end
            end
            ST_FIX: begin
                add_y   = is_div ? {1'b0, r_opj} : r_acc;
                add_sub = r_neg;
            end
            default: add_sub = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_busy        <= 1'b0;
            r_mem_station <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_mem_station <= i_cfg_wr_data;
            // Hold the entry from issue until the result moves out or a flush drops it
            if (s_xfer && in_op == OP_ISSUE && !r_busy) begin
                r_busy <= 1'b1;
            end else if (s_xfer && in_op == OP_FLUSH) begin
                r_busy <= 1'b0;
            end else if (r_state == ST_DONE && out_free) begin
                r_busy <= 1'b0;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (s_xfer && in_op == OP_ISSUE && !r_busy) begin
                    r_opcode <= in_opc;
                    r_opj    <= in_vj;
                    r_opk    <= in_vk;
                    r_wait_j <= in_tj;
                    r_wait_k <= in_tk;
                    r_addr   <= in_ba;
                    r_dest   <= in_dt;
                end else if (s_xfer && in_op == OP_BCAST && r_busy && in_bt != '0) begin
                    // Capture the broadcast into every operand waiting on this tag
                    if (r_wait_j != '0 && r_wait_j == in_bt) begin
                        r_wait_j <= '0;
                        r_opj    <= in_bv;
                    end
                    if (r_wait_k != '0 && r_wait_k == in_bt) begin
                        r_wait_k <= '0;
                        r_opk    <= in_bv;
                    end
                end
            end
            ST_START: begin
                r_acc <= '0;
                r_cnt <= '0;
                if (r_mem_station) begin
                    r_neg       <= 1'b0;
                    r_pend_dz   <= 1'b0;
                    r_pend_addr <= eff_addr;
                    if (r_opcode == OPC_LOAD) begin
                        r_pend_kind  <= KIND_LOAD;
                        r_pend_value <= '0;
                    end else begin
                        r_pend_kind  <= KIND_STORE;
                        r_pend_value <= r_opj;
                    end
                end else begin
                    r_pend_kind <= KIND_ALU;
                    r_pend_addr <= '0;
                    r_pend_dz   <= is_div && (r_opk == '0);
                    r_neg       <= is_div && (r_opj[DW-1] ^ r_opk[DW-1]);
                    unique case (r_opcode)
                        OPC_ADD, OPC_SUB: r_pend_value <= add_sum[DW-1:0];
                        OPC_SLT, OPC_SGT: r_pend_value <= DW'(add_sum[DW]);
                        OPC_DIV: begin
                            // Zero divisor leaves a zero result; otherwise take |j|
                            r_pend_value <= '0;
                            if (r_opk != '0 && r_opj[DW-1]) r_opj <= add_sum[DW-1:0];
                        end
                        default: r_pend_value <= '0;
                    endcase
                end
            end
            ST_ABS_K: begin
                if (r_opk[DW-1]) r_opk <= add_sum[DW-1:0];
            end
            ST_LOOP: begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (is_div) begin
                    // Restoring step: keep the trial remainder when it did not borrow
                    if (qbit) r_acc <= add_sum;
                    else      r_acc <= add_x;
                    r_opj <= {r_opj[DW-2:0], qbit};
                end else begin
                    if (r_opk[0]) r_acc <= {1'b0, add_sum[DW-1:0]};
                    r_opj <= {r_opj[DW-2:0], 1'b0};
                    r_opk <= {1'b0, r_opk[DW-1:1]};
                end
            end
            ST_FIX: begin
                r_pend_value <= add_sum[DW-1:0];
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_kind  <= r_pend_kind;
                    r_out_tag   <= r_dest;
                    r_out_value <= r_pend_value;
                    r_out_addr  <= r_pend_addr;
                    r_out_dz    <= r_pend_dz;
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = OUT_W'({r_out_dz, r_out_addr, r_out_value, r_out_tag});

    // An entry in flight is always held busy
    a_exec_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> r_busy)
        else $error("sequencer running on a free entry");

    // A busy entry waiting for transfers still misses an operand
    a_wait_operand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_busy) |-> (r_wait_j != '0 || r_wait_k != '0))
        else $error("busy idle entry with both operands ready");

    // A finished result reaches the output register in the next cycle
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (m_axis_tvalid && !r_busy))
        else $error("result not transferred to output register");

    // Divide by zero is only reported on ALU results
    a_dz_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out_dz) |-> (r_out_kind == KIND_ALU))
        else $error("divide by zero flag on memory request");

    // The loop leaves after exactly DATA_WIDTH steps
    a_loop_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOP && last_step) |=> (r_state == ST_FIX))
        else $error("iteration count overrun");

endmodule
